FILE: rtl/nlt_pkg.sv
// Shared constants for the nodal local time step block.
// Used by nodal_local_timestep; no dependencies.
`default_nettype none

package nlt_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int WORD_WIDTH_DEF = 32;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SAFETY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIFF     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAP_EN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_EN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED    = 3'd5;

endpackage

`default_nettype wire

FILE: rtl/nlt_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Stand-alone; instantiated by nodal_local_timestep.
`default_nettype none

module nlt_div #(
  parameter int NUM_W  = 48,
  parameter int DEN_W  = 33,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [NUM_W-1:0]  num_i,
  input  wire logic [DEN_W-1:0]  den_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   valid_o,
  output logic [NUM_W-1:0]       quo_o,
  output logic [SIDE_W-1:0]      side_o
);

  logic              vld_q  [NUM_W];
  logic [NUM_W-1:0]  num_q  [NUM_W];
  logic [NUM_W-1:0]  quo_q  [NUM_W];
  logic [DEN_W-1:0]  rem_q  [NUM_W];
  logic [DEN_W-1:0]  den_q  [NUM_W];
  logic [SIDE_W-1:0] side_q [NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic              pv;
    logic [NUM_W-1:0]  pnum;
    logic [NUM_W-1:0]  pquo;
    logic [DEN_W-1:0]  prem;
    logic [DEN_W-1:0]  pden;
    logic [SIDE_W-1:0] pside;
    logic [DEN_W:0]    sh;
    logic [DEN_W:0]    dif;
    logic              ge;

    if (i == 0) begin : g_src_in
      assign pv    = valid_i;
      assign pnum  = num_i;
      assign pquo  = '0;
      assign prem  = '0;
      assign pden  = den_i;
      assign pside = side_i;
    end else begin : g_src_reg
      assign pv    = vld_q[i-1];
      assign pnum  = num_q[i-1];
      assign pquo  = quo_q[i-1];
      assign prem  = rem_q[i-1];
      assign pden  = den_q[i-1];
      assign pside = side_q[i-1];
    end

    assign sh  = {prem, pnum[NUM_W-1]};
    assign dif = sh - {1'b0, pden};
    assign ge  = (sh >= {1'b0, pden});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[i]  <= {pnum[NUM_W-2:0], 1'b0};
        quo_q[i]  <= {pquo[NUM_W-2:0], ge};
        rem_q[i]  <= ge ? dif[DEN_W-1:0] : sh[DEN_W-1:0];
        den_q[i]  <= pden;
        side_q[i] <= pside;
      end
    end
  end

  assign valid_o = vld_q[NUM_W-1];
  assign quo_o   = quo_q[NUM_W-1];
  assign side_o  = side_q[NUM_W-1];

endmodule

`default_nettype wire

FILE: rtl/nlt_sqrt.sv
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Stand-alone; instantiated by nodal_local_timestep.
`default_nettype none

module nlt_sqrt #(
  parameter int R      = 33,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [2*R-1:0]    rad_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   valid_o,
  output logic [R-1:0]           root_o,
  output logic [SIDE_W-1:0]      side_o
);

  logic              vld_q  [R];
  logic [2*R-1:0]    rad_q  [R];
  logic [R-1:0]      root_q [R];
  logic [R+1:0]      rem_q  [R];
  logic [SIDE_W-1:0] side_q [R];

  for (genvar i = 0; i < R; i++) begin : g_stage
    logic              pv;
    logic [2*R-1:0]    prad;
    logic [R-1:0]      proot;
    logic [R+1:0]      prem;
    logic [SIDE_W-1:0] pside;
    logic [R+3:0]      sh;
    logic [R+3:0]      trial;
    logic [R+3:0]      dif;
    logic              ge;

    if (i == 0) begin : g_src_in
      assign pv    = valid_i;
      assign prad  = rad_i;
      assign proot = '0;
      assign prem  = '0;
      assign pside = side_i;
    end else begin : g_src_reg
      assign pv    = vld_q[i-1];
      assign prad  = rad_q[i-1];
      assign proot = root_q[i-1];
      assign prem  = rem_q[i-1];
      assign pside = side_q[i-1];
    end

    assign sh    = {prem, prad[2*R-1:2*R-2]};
    assign trial = {2'b00, proot, 2'b01};
    assign dif   = sh - trial;
    assign ge    = (sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[i]  <= {prad[2*R-3:0], 2'b00};
        root_q[i] <= {proot[R-2:0], ge};
        rem_q[i]  <= ge ? dif[R+1:0] : sh[R+1:0];
        side_q[i] <= pside;
      end
    end
  end

  assign valid_o = vld_q[R-1];
  assign root_o  = root_q[R-1];
  assign side_o  = side_q[R-1];

endmodule

`default_nettype wire

FILE: rtl/nodal_local_timestep.sv
// Nodal local stable time step: speed, advective and diffusive limits, step and blend.
// Depends on nlt_pkg, nlt_sqrt and nlt_div.
//
//  channel   dir  handshake              contents
//  s_axis    in   tvalid/tready          vel_x, vel_y, vel_z, node_length
//  m_axis    out  tvalid/tready          step, diffusive_limit, blend, fell_back, error
//  cfg       in   cfg_we_i (no wait)     register index and write data
//
// One item enters per cycle while m_axis does not stall. The pipeline holds three
// input stages, W+1 square root stages, W+F and 2*W divider stages for the two limits,
// a minimum and a product stage, W+F blend quotient stages and the output register.
// Reset clears all valid bits and loads the register defaults.
// A stall on m_axis freezes the whole pipeline; s_axis_tready follows it.
`default_nettype none

module nodal_local_timestep #(
  parameter int FRAC_BITS  = nlt_pkg::FRAC_BITS_DEF,
  parameter int WORD_WIDTH = nlt_pkg::WORD_WIDTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // vel_x, vel_y, vel_z, node_length from bit 0 up
  input  wire logic [((4*WORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // step, diffusive_limit, blend, fell_back, error from bit 0 up
  output logic [((2*WORD_WIDTH+FRAC_BITS+3+7)/8)*8-1:0] m_axis_tdata,
  input  wire logic                           cfg_we_i,
  input  wire logic [nlt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [WORD_WIDTH-1:0]          cfg_wdata_i
);

  localparam int W     = WORD_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int DW    = 2 * W;
  localparam int R     = W + 1;
  localparam int OUT_W = ((2*W+F+3+7)/8)*8;
  localparam logic [W-1:0] ONE_W   = W'(1) << F;
  localparam logic [F:0]   ONE_B   = {1'b1, {F{1'b0}}};
  localparam logic [W-1:0] FULL    = '1;

  // Configuration registers
  logic [W-1:0] safety_q, diff_q, cap_q, fixed_q;
  logic         cap_en_q, blend_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      safety_q   <= ONE_W;
      diff_q     <= ONE_W;
      cap_q      <= '0;
      cap_en_q   <= 1'b0;
      blend_en_q <= 1'b0;
      fixed_q    <= ONE_W;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        nlt_pkg::REG_SAFETY:   safety_q   <= cfg_wdata_i;
        nlt_pkg::REG_DIFF:     diff_q     <= cfg_wdata_i;
        nlt_pkg::REG_CAP:      cap_q      <= cfg_wdata_i;
        nlt_pkg::REG_CAP_EN:   cap_en_q   <= cfg_wdata_i[0];
        nlt_pkg::REG_BLEND_EN: blend_en_q <= cfg_wdata_i[0];
        nlt_pkg::REG_FIXED:    fixed_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic en;
  logic out_vld_q;
  logic [OUT_W-1:0] out_data_q;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // Stage A: magnitudes
  logic [W-1:0] vx, vy, vz, h_in;
  assign vx   = s_axis_tdata[W-1:0];
  assign vy   = s_axis_tdata[2*W-1:W];
  assign vz   = s_axis_tdata[3*W-1:2*W];
  assign h_in = s_axis_tdata[4*W-1:3*W];

  logic         a_vld_q;
  logic [W-1:0] a_mx_q, a_my_q, a_mz_q, a_h_q;

  // Stage B: squares
  logic          b_vld_q;
  logic [DW-1:0] b_sx_q, b_sy_q, b_sz_q, b_hh_q;
  logic [W-1:0]  b_h_q;

  // Stage C: sum of squares
  logic          c_vld_q;
  logic [DW+1:0] c_sq_q;
  logic [DW-1:0] c_hh_q;
  logic [W-1:0]  c_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= s_axis_tvalid;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_mx_q <= vx[W-1] ? (~vx + W'(1)) : vx;
      a_my_q <= vy[W-1] ? (~vy + W'(1)) : vy;
      a_mz_q <= vz[W-1] ? (~vz + W'(1)) : vz;
      a_h_q  <= h_in;
      b_sx_q <= DW'(a_mx_q) * DW'(a_mx_q);
      b_sy_q <= DW'(a_my_q) * DW'(a_my_q);
      b_sz_q <= DW'(a_mz_q) * DW'(a_mz_q);
      b_hh_q <= DW'(a_h_q) * DW'(a_h_q);
      b_h_q  <= a_h_q;
      c_sq_q <= (DW+2)'(b_sx_q) + (DW+2)'(b_sy_q) + (DW+2)'(b_sz_q);
      c_hh_q <= b_hh_q;
      c_h_q  <= b_h_q;
    end
  end

  // Speed
  logic          sq_vld;
  logic [R-1:0]  speed;
  logic [3*W-1:0] sq_side;

  nlt_sqrt #(.R(R), .SIDE_W(3*W)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (c_vld_q),
    .rad_i   (c_sq_q),
    .side_i  ({c_hh_q, c_h_q}),
    .valid_o (sq_vld),
    .root_o  (speed),
    .side_o  (sq_side)
  );

  logic [W-1:0]  sq_h;
  logic [DW-1:0] sq_hh;
  logic [R-1:0]  speed_fl;
  assign sq_h     = sq_side[W-1:0];
  assign sq_hh    = sq_side[3*W-1:W];
  assign speed_fl = (speed == '0) ? R'(1) : speed;

  // Advective limit: (h << F) / speed
  logic          ad_vld;
  logic [W+F-1:0] ad_quo;
  logic [DW:0]   ad_side;

  nlt_div #(.NUM_W(W+F), .DEN_W(R), .SIDE_W(DW+1)) u_div_adv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_vld),
    .num_i   ({sq_h, {F{1'b0}}}),
    .den_i   (speed_fl),
    .side_i  ({(sq_h == '0), sq_hh}),
    .valid_o (ad_vld),
    .quo_o   (ad_quo),
    .side_o  (ad_side)
  );

  logic [W-1:0] alim;
  assign alim = (ad_quo[W+F-1:W] != '0) ? FULL : ad_quo[W-1:0];

  // Diffusive limit: h^2 / (2 D)
  logic          df_vld;
  logic [DW-1:0] df_quo;
  logic [W:0]    df_side;

  nlt_div #(.NUM_W(DW), .DEN_W(W+1), .SIDE_W(W+1)) u_div_dif (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ad_vld),
    .num_i   (ad_side[DW-1:0]),
    .den_i   ({diff_q, 1'b0}),
    .side_i  ({ad_side[DW], alim}),
    .valid_o (df_vld),
    .quo_o   (df_quo),
    .side_o  (df_side)
  );

  logic [W-1:0] dlim;
  assign dlim = ((diff_q == '0) || (df_quo[DW-1:W] != '0)) ? FULL : df_quo[W-1:0];

  // Stage F: minimum; stage G: safety product and blend denominator
  logic         f_vld_q, f_zero_q;
  logic [W-1:0] f_alim_q, f_dlim_q, f_lim_q;
  logic          g_vld_q, g_zero_q;
  logic [DW-1:0] g_prod_q;
  logic [W:0]    g_den_q;
  logic [W-1:0]  g_dlim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
      g_vld_q <= 1'b0;
    end else if (en) begin
      f_vld_q <= df_vld;
      g_vld_q <= f_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_zero_q <= df_side[W];
      f_alim_q <= df_side[W-1:0];
      f_dlim_q <= dlim;
      f_lim_q  <= (df_side[W-1:0] < dlim) ? df_side[W-1:0] : dlim;
      g_prod_q <= DW'(safety_q) * DW'(f_lim_q);
      g_den_q  <= (W+1)'(f_alim_q) + (W+1)'(f_dlim_q);
      g_dlim_q <= f_dlim_q;
      g_zero_q <= f_zero_q;
    end
  end

  logic [W-1:0] step_sc, step_cp;
  assign step_sc = (g_prod_q[DW-1:W+F] != '0) ? FULL : g_prod_q[W+F-1:F];
  assign step_cp = (cap_en_q && (cap_q != '0) && (cap_q < step_sc)) ? cap_q : step_sc;

  // Blend: (dlim << F) / (alim + dlim)
  logic           bl_vld;
  logic [W+F-1:0] bl_quo;
  logic [DW+1:0]  bl_side;

  nlt_div #(.NUM_W(W+F), .DEN_W(W+1), .SIDE_W(DW+2)) u_div_bl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (g_vld_q),
    .num_i   ({g_dlim_q, {F{1'b0}}}),
    .den_i   (g_den_q),
    .side_i  ({g_zero_q, (g_den_q == '0), g_dlim_q, step_cp}),
    .valid_o (bl_vld),
    .quo_o   (bl_quo),
    .side_o  (bl_side)
  );

  logic         o_zero, o_den0;
  logic [W-1:0] o_dlim, o_step, r_step, r_dlim;
  logic [F:0]   o_blend, r_blend;
  logic         r_fb, r_err;

  assign o_step = bl_side[W-1:0];
  assign o_dlim = bl_side[DW-1:W];
  assign o_den0 = bl_side[DW];
  assign o_zero = bl_side[DW+1];

  always_comb begin
    if (!blend_en_q) begin
      o_blend = ONE_B;
    end else if (o_den0) begin
      o_blend = '0;
    end else if ((bl_quo[W+F-1:F+1] != '0) || (bl_quo[F:0] > ONE_B)) begin
      o_blend = ONE_B;
    end else begin
      o_blend = bl_quo[F:0];
    end
    if (o_zero) begin
      r_step  = fixed_q;
      r_dlim  = '0;
      r_blend = ONE_B;
      r_fb    = 1'b1;
    end else begin
      r_step  = o_step;
      r_dlim  = o_dlim;
      r_blend = o_blend;
      r_fb    = 1'b0;
    end
    r_err = (r_step == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= bl_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= OUT_W'({r_err, r_fb, r_blend, r_dlim, r_step});
    end
  end

endmodule

`default_nettype wire
